// ===== src/quadrotor_attitude_mixer_defines.svh =====
// assertion helpers for the attitude mixer, clocked on clk, quiet while rst is high
`ifndef QUADROTOR_ATTITUDE_MIXER_DEFINES_SVH
`define QUADROTOR_ATTITUDE_MIXER_DEFINES_SVH
// property that must hold at every edge out of reset
`define QAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never be seen
`define QAM_NEVER(lbl, cond, msg) \
  `QAM_ASSERT(lbl, !(cond), msg)
`endif

// ===== src/qam_pkg.sv =====
// ----------------------------------------------------------------------------
// qam_pkg
// Widths, fixed-point constants, codes and types shared by the mixer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qam_pkg;

  localparam int FRACTION_BITS   = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int CORDIC_N  = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;
  localparam int IW        = $clog2(CORDIC_N);

  localparam int DW = 32;              // field width
  localparam int MW = 33;              // multiplier operand width
  localparam int PW = 2 * MW;          // product width
  localparam int WW = 52;              // wide intermediate width
  localparam int CW = 34;              // cordic datapath width
  localparam int FW = 36;              // reduced angle width

  // angle reduction: yaw scaled to 30 fraction bits, remainder by 2*pi
  localparam int RSH       = 30 - FRACTION_BITS;
  localparam int RW        = 64 - FRACTION_BITS;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint CK115_Q30   = 64'sd123480310;
  localparam longint CK100_Q30   = 64'sd107374182;
  localparam longint CORDIC_X0   = 64'sd652032874 + (64'sd434688583 >>> (2 * CORDIC_N));

  // quotient estimate |yaw| * RECIP_2PI >> 32 is low by at most one
  localparam longint RECIP_2PI   = (64'sd1 <<< (RSH + 32)) / TWO_PI_Q30;

  localparam longint ONE_F    = 64'sd1 <<< FRACTION_BITS;
  localparam longint RND_Q30  = 64'sd1 <<< (RSH - 1);
  localparam longint PI_F     = (PI_Q30 + RND_Q30) >>> RSH;
  localparam longint TWO_PI_F = (TWO_PI_Q30 + RND_Q30) >>> RSH;
  localparam longint G115_F   = (CK115_Q30 + RND_Q30) >>> RSH;
  localparam longint G100_F   = (CK100_Q30 + RND_Q30) >>> RSH;

  // configuration register indexes
  localparam logic [3:0] REG_HOVER    = 4'd0;
  localparam logic [3:0] REG_ALT_OFS  = 4'd1;
  localparam logic [3:0] REG_VERT     = 4'd2;
  localparam logic [3:0] REG_ROLL     = 4'd3;
  localparam logic [3:0] REG_PITCH    = 4'd4;
  localparam logic [3:0] REG_HEADING  = 4'd5;
  localparam logic [3:0] REG_POSITION = 4'd6;
  localparam logic [3:0] REG_VELOCITY = 4'd7;

  typedef enum logic [1:0] {ST_IDLE, ST_TRIG, ST_MUL, ST_OUT} state_t;
  typedef enum logic [2:0] {CS_IDLE, CS_QUO, CS_RED, CS_CORR, CS_FOLD, CS_ITER} cstate_t;

  typedef enum logic [4:0] {
    OP_YAW, OP_FE_A, OP_FE_B, OP_SE_A, OP_SE_B, OP_FV_A, OP_FV_B, OP_SV_A, OP_SV_B,
    OP_PD_A, OP_PD_B, OP_RD_A, OP_RD_B, OP_ROLL, OP_PITCH, OP_SQ, OP_CUBE, OP_VERT,
    OP_GROLL, OP_GPITCH
  } step_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] sin_v;
    logic signed [DW-1:0] cos_v;
  } trig_t;

endpackage

// ===== src/qam_mul.sv =====
// ----------------------------------------------------------------------------
// qam_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qam_mul
  import qam_pkg::*;
(
  input  logic                 clk,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [PW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== src/qam_cordic.sv =====
// ----------------------------------------------------------------------------
// qam_cordic
// Iterative sine and cosine of yaw: remainder by 2*pi, quadrant fold, rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qam_cordic
  import qam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] yaw,
  output trig_t                trig
);

  cstate_t               cst, cst_next;
  logic [RW-1:0]         mag, mag_next;
  logic                  neg, neg_next;
  logic [RSH-1:0]        quo, quo_next;
  logic                  flip, flip_next;
  logic [IW-1:0]         iter, iter_next;
  logic signed [CW-1:0]  x, x_next, y, y_next, z, z_next;
  logic signed [DW-1:0]  sin_v, sin_next, cos_v, cos_next;
  logic                  done, done_next;

  logic signed [RW-1:0]  r_in;
  logic [RW-1:0]         tk, recip_prod, qprod;
  logic signed [FW-1:0]  rr;
  logic signed [CW-1:0]  dx, dy, at, xn, yn, zn;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = CW'(843314857);
      5'd1:  v = CW'(497837829);
      5'd2:  v = CW'(263043837);
      5'd3:  v = CW'(133525159);
      5'd4:  v = CW'(67021687);
      5'd5:  v = CW'(33543516);
      5'd6:  v = CW'(16775851);
      5'd7:  v = CW'(8388437);
      5'd8:  v = CW'(4194283);
      5'd9:  v = CW'(2097149);
      5'd10: v = CW'(1048576);
      5'd11: v = CW'(524288);
      5'd12: v = CW'(262144);
      5'd13: v = CW'(131072);
      5'd14: v = CW'(65536);
      5'd15: v = CW'(32768);
      5'd16: v = CW'(16384);
      5'd17: v = CW'(8192);
      5'd18: v = CW'(4096);
      5'd19: v = CW'(2048);
      5'd20: v = CW'(1024);
      5'd21: v = CW'(512);
      5'd22: v = CW'(256);
      5'd23: v = CW'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cst  <= CS_IDLE;
      done <= 1'b0;
    end else begin
      cst  <= cst_next;
      done <= done_next;
    end
    mag   <= mag_next;
    neg   <= neg_next;
    quo   <= quo_next;
    flip  <= flip_next;
    iter  <= iter_next;
    x     <= x_next;
    y     <= y_next;
    z     <= z_next;
    sin_v <= sin_next;
    cos_v <= cos_next;
  end

  always_comb begin
    cst_next   = cst;
    mag_next   = mag;
    neg_next   = neg;
    quo_next   = quo;
    flip_next  = flip;
    iter_next  = iter;
    x_next     = x;
    y_next     = y;
    z_next     = z;
    sin_next   = sin_v;
    cos_next   = cos_v;
    done_next  = 1'b0;
    r_in       = RW'(yaw) <<< RSH;
    tk         = RW'(TWO_PI_Q30);
    // upper bits of mag hold |yaw| exactly
    recip_prod = RW'(mag[RW-1:RSH]) * RW'(RECIP_2PI);
    qprod      = RW'(quo) * RW'(TWO_PI_Q30);
    rr         = neg ? -$signed(mag[FW-1:0]) : $signed(mag[FW-1:0]);
    dx         = x >>> iter;
    dy         = y >>> iter;
    at         = atan_q30(5'(iter));
    xn         = z[CW-1] ? x + dy : x - dy;
    yn         = z[CW-1] ? y - dx : y + dx;
    zn         = z[CW-1] ? z + at : z - at;
    case (cst)
      CS_IDLE: begin
        if (start) begin
          mag_next = r_in[RW-1] ? RW'(-r_in) : RW'(r_in);
          neg_next = yaw[DW-1];
          cst_next = CS_QUO;
        end
      end
      CS_QUO: begin
        quo_next = recip_prod[RSH+31:32];
        cst_next = CS_RED;
      end
      CS_RED: begin
        mag_next = mag - qprod;
        cst_next = CS_CORR;
      end
      CS_CORR: begin
        // estimate may be one short
        if (mag >= tk) mag_next = mag - tk;
        cst_next = CS_FOLD;
      end
      CS_FOLD: begin
        // remainder keeps the sign of yaw, then one wrap into plus or minus pi
        if (rr > FW'(PI_Q30)) rr = rr - FW'(TWO_PI_Q30);
        else if (rr < -FW'(PI_Q30)) rr = rr + FW'(TWO_PI_Q30);
        flip_next = 1'b0;
        if (rr > FW'(HALF_PI_Q30)) begin
          rr = rr - FW'(PI_Q30);
          flip_next = 1'b1;
        end else if (rr < -FW'(HALF_PI_Q30)) begin
          rr = rr + FW'(PI_Q30);
          flip_next = 1'b1;
        end
        z_next    = CW'(rr);
        x_next    = CW'(CORDIC_X0);
        y_next    = '0;
        iter_next = '0;
        cst_next  = CS_ITER;
      end
      CS_ITER: begin
        x_next = xn;
        y_next = yn;
        z_next = zn;
        if (iter == IW'(CORDIC_N - 1)) begin
          sin_next  = flip ? DW'(-yn) : DW'(yn);
          cos_next  = flip ? DW'(-xn) : DW'(xn);
          done_next = 1'b1;
          cst_next  = CS_IDLE;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      default: cst_next = CS_IDLE;
    endcase
  end

  assign trig.done  = done;
  assign trig.sin_v = sin_v;
  assign trig.cos_v = cos_v;

endmodule

// ===== src/quadrotor_attitude_mixer.sv =====
// sequence: angle reduction and cordic, then 20 products on the shared multiplier,
//   then the mix into the registered output word
// input: new word taken only while the sequencer idles
// reset: synchronous, restores register defaults, clears previous position, first tick set
`timescale 1ns / 1ps
`include "quadrotor_attitude_mixer_defines.svh"

// ----------------------------------------------------------------------------
// quadrotor_attitude_mixer
// PD attitude and position control mixed into four propeller speeds and a gimbal.
// ----------------------------------------------------------------------------
module quadrotor_attitude_mixer
  import qam_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // roll_angle, pitch_angle, yaw_angle, altitude, roll_rate, pitch_rate,
  // position_x, position_y, goal_x, goal_y, goal_altitude, goal_heading
  input  logic [383:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // front_left_speed, front_right_speed, rear_left_speed, rear_right_speed,
  // gimbal_roll, gimbal_pitch
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  state_t state, state_next;
  step_t  step, step_next;
  logic   phase, phase_next;

  logic [30:0]        hover_thrust, vertical_gain, roll_gain, pitch_gain;
  logic [30:0]        heading_gain, position_gain, velocity_gain;
  logic signed [31:0] altitude_offset;

  logic signed [DW-1:0] last_x, last_y;
  logic                 first_tick;

  logic signed [DW-1:0] in_roll, in_pitch, in_yaw, in_alt, in_rroll, in_rpitch;
  logic signed [DW-1:0] in_px, in_py, in_gx, in_gy, in_galt, in_ghead;

  logic signed [WW-1:0] roll_c, pitch_c, ae, yaw_in, pd, rd, roll_in, pitch_cmd, vert;
  logic signed [DW-1:0] ex, ey, vx, vy, yerr, fe, se, fv, sv, tmp, g_roll, g_pitch;
  logic signed [PW-1:0] acc, prod;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [WW-1:0] pr16, ydiff, base, m0, m1, m2, m3;
  logic                 accept, out_valid;
  logic [191:0]         out_data;
  trig_t                trig;

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > PW'(64'sd2147483647)) r = 32'sh7fffffff;
    else if (v < -PW'(64'sd2147483648)) r = 32'sh80000000;
    else r = DW'(v);
    return r;
  endfunction

  function automatic logic signed [WW-1:0] clampw(input logic signed [WW-1:0] v,
                                                  input logic signed [WW-1:0] lim);
    logic signed [WW-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [PW-1:0] r30(input logic signed [PW-1:0] v);
    return (v + PW'(64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [MW-1:0] ug(input logic [30:0] g);
    return $signed({2'b00, g});
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  qam_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .yaw   ($signed(s_axis_tdata[95:64])),
    .trig  (trig)
  );

  qam_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign pr16 = WW'((prod + PW'(64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);

  // operand select for the step in flight
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      OP_YAW:    begin mul_a = ug(heading_gain);  mul_b = MW'(yerr); end
      OP_FE_A:   begin mul_a = MW'(trig.cos_v);   mul_b = MW'(ex); end
      OP_FE_B:   begin mul_a = MW'(trig.sin_v);   mul_b = MW'(ey); end
      OP_SE_A:   begin mul_a = MW'(trig.cos_v);   mul_b = MW'(ey); end
      OP_SE_B:   begin mul_a = MW'(trig.sin_v);   mul_b = MW'(ex); end
      OP_FV_A:   begin mul_a = MW'(trig.cos_v);   mul_b = MW'(vx); end
      OP_FV_B:   begin mul_a = MW'(trig.sin_v);   mul_b = MW'(vy); end
      OP_SV_A:   begin mul_a = MW'(trig.cos_v);   mul_b = MW'(vy); end
      OP_SV_B:   begin mul_a = MW'(trig.sin_v);   mul_b = MW'(vx); end
      OP_PD_A:   begin mul_a = ug(velocity_gain); mul_b = MW'(fv); end
      OP_PD_B:   begin mul_a = ug(position_gain); mul_b = MW'(fe); end
      OP_RD_A:   begin mul_a = ug(position_gain); mul_b = MW'(se); end
      OP_RD_B:   begin mul_a = ug(velocity_gain); mul_b = MW'(sv); end
      OP_ROLL:   begin mul_a = ug(roll_gain);     mul_b = MW'(roll_c); end
      OP_PITCH:  begin mul_a = ug(pitch_gain);    mul_b = MW'(pitch_c); end
      OP_SQ:     begin mul_a = MW'(ae);           mul_b = MW'(ae); end
      OP_CUBE:   begin mul_a = MW'(tmp);          mul_b = MW'(ae); end
      OP_VERT:   begin mul_a = ug(vertical_gain); mul_b = MW'(tmp); end
      OP_GROLL:  begin mul_a = MW'(-G115_F);      mul_b = MW'(in_rroll); end
      OP_GPITCH: begin mul_a = MW'(-G100_F);      mul_b = MW'(in_rpitch); end
      default:   begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= OP_YAW;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    phase_next = phase;
    case (state)
      ST_IDLE: if (accept) state_next = ST_TRIG;
      ST_TRIG: begin
        if (trig.done) begin
          state_next = ST_MUL;
          step_next  = OP_YAW;
          phase_next = 1'b0;
        end
      end
      ST_MUL: begin
        phase_next = !phase;
        if (phase) begin
          if (step == OP_GPITCH) state_next = ST_OUT;
          else step_next = step_t'(step + 5'd1);
        end
      end
      ST_OUT: if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration and previous position
  always_ff @(posedge clk) begin
    if (rst) begin
      hover_thrust    <= 31'd4489216;
      altitude_offset <= 32'sd39322;
      vertical_gain   <= 31'd196608;
      roll_gain       <= 31'd3276800;
      pitch_gain      <= 31'd1966080;
      heading_gain    <= 31'd131072;
      position_gain   <= 31'd131072;
      velocity_gain   <= 31'd40960000;
      last_x          <= '0;
      last_y          <= '0;
      first_tick      <= 1'b1;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_HOVER:    hover_thrust    <= cfg_data[30:0];
          REG_ALT_OFS:  altitude_offset <= $signed(cfg_data);
          REG_VERT:     vertical_gain   <= cfg_data[30:0];
          REG_ROLL:     roll_gain       <= cfg_data[30:0];
          REG_PITCH:    pitch_gain      <= cfg_data[30:0];
          REG_HEADING:  heading_gain    <= cfg_data[30:0];
          REG_POSITION: position_gain   <= cfg_data[30:0];
          REG_VELOCITY: velocity_gain   <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (accept) begin
        last_x     <= $signed(s_axis_tdata[223:192]);
        last_y     <= $signed(s_axis_tdata[255:224]);
        first_tick <= 1'b0;
      end
    end
  end

  assign in_roll   = $signed(s_axis_tdata[31:0]);
  assign in_pitch  = $signed(s_axis_tdata[63:32]);
  assign in_yaw    = $signed(s_axis_tdata[95:64]);
  assign in_alt    = $signed(s_axis_tdata[127:96]);
  assign in_px     = $signed(s_axis_tdata[223:192]);
  assign in_py     = $signed(s_axis_tdata[255:224]);
  assign in_gx     = $signed(s_axis_tdata[287:256]);
  assign in_gy     = $signed(s_axis_tdata[319:288]);
  assign in_galt   = $signed(s_axis_tdata[351:320]);
  assign in_ghead  = $signed(s_axis_tdata[383:352]);

  always_comb begin
    ydiff = WW'(in_ghead) - WW'(in_yaw);
    if (ydiff > WW'(PI_F)) ydiff = ydiff - WW'(TWO_PI_F);
    else if (ydiff < -WW'(PI_F)) ydiff = ydiff + WW'(TWO_PI_F);
  end

  // input word capture and per-step results
  always_ff @(posedge clk) begin
    if (accept) begin
      in_rroll  <= $signed(s_axis_tdata[159:128]);
      in_rpitch <= $signed(s_axis_tdata[191:160]);
      roll_c    <= clampw(WW'(in_roll), WW'(ONE_F));
      pitch_c   <= clampw(WW'(in_pitch), WW'(ONE_F));
      ae        <= clampw(WW'(in_galt) - WW'(in_alt) + WW'(altitude_offset), WW'(ONE_F));
      ex        <= sat32(PW'(in_gx) - PW'(in_px));
      ey        <= sat32(PW'(in_gy) - PW'(in_py));
      vx        <= first_tick ? '0 : sat32(PW'(in_px) - PW'(last_x));
      vy        <= first_tick ? '0 : sat32(PW'(in_py) - PW'(last_y));
      yerr      <= sat32(PW'(ydiff));
    end
    if (state == ST_MUL && phase) begin
      case (step)
        OP_YAW:    yaw_in    <= clampw(pr16, WW'(ONE_F));
        OP_FE_A:   acc       <= prod;
        OP_FE_B:   fe        <= sat32(r30(acc + prod));
        OP_SE_A:   acc       <= prod;
        OP_SE_B:   se        <= sat32(r30(acc - prod));
        OP_FV_A:   acc       <= prod;
        OP_FV_B:   fv        <= sat32(r30(acc + prod));
        OP_SV_A:   acc       <= prod;
        OP_SV_B:   sv        <= sat32(r30(acc - prod));
        OP_PD_A:   acc       <= PW'(pr16);
        OP_PD_B:   pd        <= clampw(WW'(acc) - pr16, WW'(2 * ONE_F));
        OP_RD_A:   acc       <= PW'(pr16);
        OP_RD_B:   rd        <= clampw(WW'(acc) - pr16, WW'(2 * ONE_F));
        OP_ROLL:   roll_in   <= pr16 + WW'(in_rroll) + rd;
        OP_PITCH:  pitch_cmd <= pr16 + WW'(in_rpitch) + pd;
        OP_SQ:     tmp       <= DW'(pr16);
        OP_CUBE:   tmp       <= DW'(pr16);
        OP_VERT:   vert      <= pr16;
        OP_GROLL:  g_roll    <= sat32(PW'(pr16));
        OP_GPITCH: g_pitch   <= sat32(PW'(pr16));
        default: ;
      endcase
    end
  end

  // motor mix
  always_comb begin
    base = WW'(hover_thrust) + vert;
    m0   = base - roll_in + pitch_cmd - yaw_in;
    m1   = base + roll_in + pitch_cmd + yaw_in;
    m2   = base - roll_in - pitch_cmd + yaw_in;
    m3   = base + roll_in - pitch_cmd - yaw_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_OUT && (!out_valid || m_axis_tready)) begin
      out_data <= {g_pitch, g_roll, sat32(PW'(m3)), sat32(-PW'(m2)),
                   sat32(-PW'(m1)), sat32(PW'(m0))};
    end
  end

  `QAM_ASSERT(a_busy_after_accept, accept |=> !s_axis_tready, "ready high after accept")
  `QAM_NEVER(a_trig_outside_wait, trig.done && state != ST_TRIG, "cordic done while not waiting")
  `QAM_ASSERT(a_last_step_ends, (state == ST_MUL && phase && step == OP_GPITCH) |=> state == ST_OUT, "sequence did not end")

endmodule

// ===== tb/tb_quadrotor_attitude_mixer.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_quadrotor_attitude_mixer
// Streams control ticks through the mixer and checks every output word against
// a bit-exact fixed-point model of the controller kept in the testbench, across
// several gain settings, random stalls on both buses and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_quadrotor_attitude_mixer;
  import qam_pkg::*;

  localparam int  IDLE_LIMIT = 6000;
  localparam int  DRAIN_WAIT = 100;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint ATAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [383:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [3:0]   cfg_index;
  logic [31:0]  cfg_data;

  // controller state and gains as the testbench sees them
  longint hover, alt_ofs, vert_gain, roll_k, pitch_k, head_k, pos_k, vel_k;
  longint prev_x, prev_y;
  bit     first_sample;

  logic [191:0] pending_mix[$];
  int     mismatches;
  int     idle_cycles;
  int     hold_len;
  bit     no_gaps;

  quadrotor_attitude_mixer i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    return (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return round_shift(a * b, FRACTION_BITS);
  endfunction

  function automatic longint fld(logic [383:0] d, int i);
    return longint'($signed(d[i*32 +: 32]));
  endfunction

  // sine and cosine of the yaw, both with 30 fraction bits
  task automatic yaw_sincos(input longint yaw, output longint sn, output longint cs);
    longint r, q, x, y, z, nx;
    bit     flip;
    r = yaw * (64'sd1 <<< RSH);
    q = r / TWO_PI_Q30;
    r = r - q * TWO_PI_Q30;
    flip = 1'b0;
    if (r > PI_Q30) r = r - TWO_PI_Q30;
    if (r < -PI_Q30) r = r + TWO_PI_Q30;
    if (r > HALF_PI_Q30) begin
      r = r - PI_Q30;
      flip = 1'b1;
    end else if (r < -HALF_PI_Q30) begin
      r = r + PI_Q30;
      flip = 1'b1;
    end
    x = CORDIC_X0;
    y = 0;
    z = r;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_Q30[i];
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // motor and gimbal word for one tick, advances the previous-position state
  task automatic predict_mix(input logic [383:0] d, output logic [191:0] w);
    longint one, vx, vy, ex, ey, sn, cs, yerr, yaw_in, fe, se, fv, sv, pd, rd;
    longint roll_in, pitch_cmd, ae, cube, vert, base;
    longint m [6];
    one = ONE_F;
    if (first_sample) begin
      vx = 0;
      vy = 0;
    end else begin
      vx = sat32(fld(d, 6) - prev_x);
      vy = sat32(fld(d, 7) - prev_y);
    end
    prev_x = fld(d, 6);
    prev_y = fld(d, 7);
    first_sample = 1'b0;

    yerr = fld(d, 11) - fld(d, 2);
    if (yerr > PI_F) yerr = yerr - TWO_PI_F;
    else if (yerr < -PI_F) yerr = yerr + TWO_PI_F;
    yaw_in = clip(fx_mul(head_k, sat32(yerr)), -one, one);

    yaw_sincos(fld(d, 2), sn, cs);
    ex = sat32(fld(d, 8) - fld(d, 6));
    ey = sat32(fld(d, 9) - fld(d, 7));
    fe = sat32(round_shift(cs * ex + sn * ey, 30));
    se = sat32(round_shift(cs * ey - sn * ex, 30));
    fv = sat32(round_shift(cs * vx + sn * vy, 30));
    sv = sat32(round_shift(cs * vy - sn * vx, 30));
    pd = clip(fx_mul(vel_k, fv) - fx_mul(pos_k, fe), -2 * one, 2 * one);
    rd = clip(fx_mul(pos_k, se) - fx_mul(vel_k, sv), -2 * one, 2 * one);

    roll_in   = fx_mul(roll_k, clip(fld(d, 0), -one, one)) + fld(d, 4) + rd;
    pitch_cmd = fx_mul(pitch_k, clip(fld(d, 1), -one, one)) + fld(d, 5) + pd;
    ae   = clip(fld(d, 10) - fld(d, 3) + alt_ofs, -one, one);
    cube = fx_mul(fx_mul(ae, ae), ae);
    vert = fx_mul(vert_gain, cube);
    base = hover + vert;

    m[0] = sat32(base - roll_in + pitch_cmd - yaw_in);
    m[1] = sat32(-(base + roll_in + pitch_cmd + yaw_in));
    m[2] = sat32(-(base - roll_in - pitch_cmd + yaw_in));
    m[3] = sat32(base + roll_in - pitch_cmd - yaw_in);
    m[4] = sat32(fx_mul(-G115_F, fld(d, 4)));
    m[5] = sat32(fx_mul(-G100_F, fld(d, 5)));
    for (int k = 0; k < 6; k++) w[k*32 +: 32] = m[k][31:0];
  endtask

  // one tick into the block, with a random gap in front of it unless no_gaps is set
  task automatic send_tick(input logic [383:0] d);
    int gap;
    logic [191:0] w;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_mix(d, w);
    pending_mix.push_back(w);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HOVER:    hover     = longint'(val[30:0]);
      REG_ALT_OFS:  alt_ofs   = longint'($signed(val));
      REG_VERT:     vert_gain = longint'(val[30:0]);
      REG_ROLL:     roll_k    = longint'(val[30:0]);
      REG_PITCH:    pitch_k   = longint'(val[30:0]);
      REG_HEADING:  head_k    = longint'(val[30:0]);
      REG_POSITION: pos_k     = longint'(val[30:0]);
      REG_VELOCITY: vel_k     = longint'(val[30:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] v [8]);
    write_reg(REG_HOVER, v[0]);
    write_reg(REG_ALT_OFS, v[1]);
    write_reg(REG_VERT, v[2]);
    write_reg(REG_ROLL, v[3]);
    write_reg(REG_PITCH, v[4]);
    write_reg(REG_HEADING, v[5]);
    write_reg(REG_POSITION, v[6]);
    write_reg(REG_VELOCITY, v[7]);
  endtask

  function automatic logic [383:0] pack_tick(longint f [12]);
    logic [383:0] d;
    for (int i = 0; i < 12; i++) d[i*32 +: 32] = f[i][31:0];
    return d;
  endfunction

  function automatic longint near_value(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly flight-like ticks, some fully random, some at the field limits
  function automatic logic [383:0] rand_tick();
    logic [383:0] d;
    longint f [12];
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      f[0] = near_value(140000);
      f[1] = near_value(140000);
      f[2] = near_value(205887);
      f[3] = near_value(1000000);
      f[4] = near_value(600000);
      f[5] = near_value(600000);
      f[6] = prev_x + near_value(20000);
      f[7] = prev_y + near_value(20000);
      f[8] = near_value(2000000);
      f[9] = near_value(2000000);
      f[10] = near_value(1000000);
      f[11] = near_value(205887);
      d = pack_tick(f);
    end else if (mode < 9) begin
      for (int i = 0; i < 12; i++) d[i*32 +: 32] = $urandom();
    end else begin
      for (int i = 0; i < 12; i++)
        case ($urandom_range(0, 3))
          0: d[i*32 +: 32] = 32'h7fff_ffff;
          1: d[i*32 +: 32] = 32'h8000_0000;
          2: d[i*32 +: 32] = 32'h0;
          default: d[i*32 +: 32] = $urandom();
        endcase
    end
    return d;
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_tick(rand_tick());
    stop_sending();
  endtask

  // first tick, limits, heading wrap both ways, yaw past pi, clamps, velocity saturation, rate limits
  task automatic test_directed();
    longint f [12];
    f = '{default: 0};
    send_tick(pack_tick(f));
    f = '{default: S32_MAX};
    send_tick(pack_tick(f));
    f = '{default: S32_MIN};
    send_tick(pack_tick(f));
    f = '{default: 0};
    f[2] = 190000; f[11] = -190000;
    send_tick(pack_tick(f));
    f[2] = -190000; f[11] = 190000;
    send_tick(pack_tick(f));
    f[2] = 205887; f[11] = -205887;
    send_tick(pack_tick(f));
    f[2] = 5000000; f[11] = 0;
    send_tick(pack_tick(f));
    f[2] = -5000000;
    send_tick(pack_tick(f));
    f[2] = 102944; f[0] = 200000; f[1] = -200000;
    send_tick(pack_tick(f));
    f[2] = 0; f[0] = -65536; f[1] = 65536; f[3] = 2000000; f[10] = -2000000;
    send_tick(pack_tick(f));
    f[3] = -2000000; f[10] = 2000000;
    send_tick(pack_tick(f));
    f = '{default: 0};
    f[6] = S32_MIN; f[7] = S32_MAX;
    send_tick(pack_tick(f));
    f[6] = S32_MAX; f[7] = S32_MIN; f[8] = S32_MIN; f[9] = S32_MAX;
    send_tick(pack_tick(f));
    f[6] = 65536; f[7] = -65536; f[8] = 131072; f[9] = 0; f[2] = 51472;
    send_tick(pack_tick(f));
    f[6] = 70000; f[7] = -60000;
    send_tick(pack_tick(f));
    f = '{default: 0};
    f[4] = S32_MAX; f[5] = S32_MIN;
    send_tick(pack_tick(f));
    f[4] = S32_MIN; f[5] = S32_MAX;
    send_tick(pack_tick(f));
    stop_sending();
    wait_drained();
  endtask

  task automatic test_gain_settings();
    logic [31:0] v [8];
    v = '{default: 32'h0};
    write_all(v);
    run_random(60);
    wait_drained();
    v = '{default: 32'hffff_ffff};
    v[1] = 32'h7fff_ffff;
    write_all(v);
    run_random(60);
    wait_drained();
    v[1] = 32'h8000_0000;
    write_all(v);
    run_random(60);
    wait_drained();
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 8; i++) v[i] = $urandom() >> $urandom_range(0, 20);
      v[1] = $urandom_range(0, 1) ? -($urandom() >> 12) : ($urandom() >> 12);
      write_all(v);
      run_random(60);
      wait_drained();
    end
    // back to flight-like gains for the bulk of the run
    v = '{32'd4489216, 32'd39322, 32'd196608, 32'd3276800, 32'd1966080,
          32'd131072, 32'd131072, 32'd40960000};
    write_all(v);
  endtask

  task automatic test_output_holdoff();
    hold_len = 600;
    no_gaps = 1'b1;
    run_random(20);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_no_stalls();
    no_gaps = 1'b1;
    run_random(150);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // output side: random stall per word, plus an occasional long hold-off
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      stall = stall + hold_len;
      hold_len = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    logic [191:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_mix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", m_axis_tdata);
      end else begin
        want = pending_mix.pop_front();
        for (int k = 0; k < 6; k++)
          if (m_axis_tdata[k*32 +: 32] !== want[k*32 +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("output field %0d: expected %h, got %h", k,
                       want[k*32 +: 32], m_axis_tdata[k*32 +: 32]);
          end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_HOVER;
    cfg_data  = '0;
    mismatches = 0;
    idle_cycles = 0;
    hold_len = 0;
    no_gaps = 1'b0;
    hover = 4489216; alt_ofs = 39322; vert_gain = 196608; roll_k = 3276800;
    pitch_k = 1966080; head_k = 131072; pos_k = 131072; vel_k = 40960000;
    prev_x = 0; prev_y = 0; first_sample = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_gain_settings();
    test_output_holdoff();
    test_no_stalls();
    run_random(1150);
    wait_drained();

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
